### hw/rtl/mdd_pkg.sv
package mdd_pkg;

	// Payload widths of the channels.
	localparam int FUND_W  = 48;
	localparam int RATIO_W = 17;
	localparam int POS_W   = 12;
	localparam int SUM_W   = 32;

	// Defaults of the top-level parameters.
	localparam int MAX_SAMPLES_DEF         = 4096;
	localparam int VALUE_BITS_DEF          = 48;
	localparam int RATIO_FRACTION_BITS_DEF = 16;

endpackage

### hw/rtl/mdd_if.sv
interface mdd_in_if;
	logic                       valid;
	logic                       ready;
	logic [mdd_pkg::FUND_W-1:0] fund_value;
	logic                       series_end;

	modport source (output valid, output fund_value, output series_end, input ready);
	modport sink (input valid, input fund_value, input series_end, output ready);
endinterface

interface mdd_out_if;
	logic                        valid;
	logic                        ready;
	logic [mdd_pkg::RATIO_W-1:0] drawdown_ratio;
	logic [mdd_pkg::POS_W-1:0]   peak_position;
	logic [mdd_pkg::POS_W-1:0]   trough_position;
	logic [mdd_pkg::SUM_W-1:0]   ratio_sum;

	modport source (output valid, output drawdown_ratio, output peak_position,
		output trough_position, output ratio_sum, input ready);
	modport sink (input valid, input drawdown_ratio, input peak_position,
		input trough_position, input ratio_sum, output ready);
endinterface

### hw/rtl/mdd_div.sv
// Restoring fraction divider: quot = floor(dividend * 2^FRAC_BITS / divisor),
// one quotient bit per cycle. Requires dividend < divisor.
module mdd_div #(
	parameter int VALUE_BITS = mdd_pkg::VALUE_BITS_DEF,
	parameter int FRAC_BITS  = mdd_pkg::RATIO_FRACTION_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] dividend,
	input  logic [VALUE_BITS-1:0] divisor,
	output logic                  done,
	output logic [FRAC_BITS-1:0]  quot
);
	import mdd_pkg::*;

	localparam int CW = $clog2(FRAC_BITS + 1);

	logic [VALUE_BITS-1:0] rem_q;
	logic [VALUE_BITS-1:0] div_q;
	logic [FRAC_BITS-1:0]  quot_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [VALUE_BITS:0]   shifted;
	logic [VALUE_BITS:0]   trial;
	logic                  fits;

	always_comb begin
		shifted = {rem_q, 1'b0};
		trial   = shifted - {1'b0, div_q};
		fits    = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(FRAC_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= dividend;
			div_q  <= divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? trial[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
			quot_q <= {quot_q[FRAC_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

### hw/rtl/max_drawdown_tracker_top.sv
// Streaming maximum drawdown tracker. Each input item carries one unsigned fund
// value and a flag that marks the last sample of a series. The block keeps the
// running peak (earliest occurrence wins on ties), forms the drop ratio
// (peak - value) / peak as an unsigned Q1.RATIO_FRACTION_BITS fraction truncated
// toward zero, and remembers the largest ratio with its peak and trough sample
// positions. A zero value gives exactly 1.0, and a zero peak gives 0. On the
// last item of a series one result item is sent: the maximum ratio, both
// positions and a saturating 32-bit sum of the maximum ratios of all finished
// series; then the per-series state is cleared. One item at a time is worked
// on. An item that needs a division waits for the shared divider, which retires
// one quotient bit per cycle; an item with a zero value, a zero peak or no drop
// skips the divider. A last item takes one step more, and it waits in that
// final step for as long as the output register is full and not draining.
module max_drawdown_tracker_top #(
	parameter int MAX_SAMPLES         = mdd_pkg::MAX_SAMPLES_DEF,
	parameter int VALUE_BITS          = mdd_pkg::VALUE_BITS_DEF,
	parameter int RATIO_FRACTION_BITS = mdd_pkg::RATIO_FRACTION_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	mdd_in_if.sink      samples,
	mdd_out_if.source   results
);
	import mdd_pkg::*;

	localparam int VB = VALUE_BITS;
	localparam int FB = RATIO_FRACTION_BITS;
	localparam int RB = FB + 1;
	localparam int IW = $clog2(MAX_SAMPLES);
	localparam logic [IW-1:0] LAST_IDX = IW'(MAX_SAMPLES - 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PEAK,
		S_PREP,
		S_DIV,
		S_BEST,
		S_EMIT
	} state_t;

	state_t state_q;

	// Sample being worked on.
	logic [VB-1:0] value_q;
	logic          last_q;
	logic [VB-1:0] value_in;

	// Per-series state.
	logic [VB-1:0] peak_q;
	logic [IW-1:0] peak_idx_q;
	logic [IW-1:0] sample_idx_q;
	logic [RB-1:0] ratio_q;
	logic [RB-1:0] best_ratio_q;
	logic [IW-1:0] best_peak_q;
	logic [IW-1:0] best_trough_q;
	logic [SUM_W-1:0] total_q;

	// Output register.
	logic          out_valid_q;
	logic [RB-1:0] out_ratio_q;
	logic [IW-1:0] out_peak_q;
	logic [IW-1:0] out_trough_q;
	logic [SUM_W-1:0] out_sum_q;

	logic          div_start;
	logic          div_done;
	logic [FB-1:0] div_quot;
	logic [VB-1:0] diff;
	logic [SUM_W:0] sum_wide;

	// Bits of fund_value above VALUE_BITS are ignored.
	generate
		if (VB > FUND_W) begin : g_val_ext
			assign value_in = {{(VB - FUND_W){1'b0}}, samples.fund_value};
		end else begin : g_val_cut
			assign value_in = samples.fund_value[VB-1:0];
		end
	endgenerate

	assign samples.ready = (state_q == S_IDLE);

	assign diff      = peak_q - value_q;
	assign div_start = (state_q == S_PREP) && (peak_q != '0) && (value_q < peak_q)
		&& (value_q != '0);
	assign sum_wide  = {1'b0, total_q} + (SUM_W + 1)'(best_ratio_q);

	mdd_div #(
		.VALUE_BITS (VB),
		.FRAC_BITS  (FB)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (diff),
		.divisor  (peak_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			value_q       <= '0;
			last_q        <= 1'b0;
			peak_q        <= '0;
			peak_idx_q    <= '0;
			sample_idx_q  <= '0;
			ratio_q       <= '0;
			best_ratio_q  <= '0;
			best_peak_q   <= '0;
			best_trough_q <= '0;
			total_q       <= '0;
			out_valid_q   <= 1'b0;
			out_ratio_q   <= '0;
			out_peak_q    <= '0;
			out_trough_q  <= '0;
			out_sum_q     <= '0;
		end else begin
			// The final step refills the output register itself when it drains.
			if (out_valid_q && results.ready && (state_q != S_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (samples.valid) begin
						value_q <= value_in;
						last_q  <= samples.series_end;
						state_q <= S_PEAK;
					end
				end
				S_PEAK: begin
					// A strictly larger value becomes the new peak.
					if (value_q > peak_q) begin
						peak_q     <= value_q;
						peak_idx_q <= sample_idx_q;
					end
					state_q <= S_PREP;
				end
				S_PREP: begin
					if (div_start) begin
						state_q <= S_DIV;
					end else begin
						// No drop gives 0; a zero sample under a nonzero peak is exactly 1.0.
						if ((peak_q != '0) && (value_q < peak_q)) begin
							ratio_q <= {1'b1, {FB{1'b0}}};
						end else begin
							ratio_q <= '0;
						end
						state_q <= S_BEST;
					end
				end
				S_DIV: begin
					if (div_done) begin
						ratio_q <= {1'b0, div_quot};
						state_q <= S_BEST;
					end
				end
				S_BEST: begin
					if (ratio_q > best_ratio_q) begin
						best_ratio_q  <= ratio_q;
						best_peak_q   <= peak_idx_q;
						best_trough_q <= sample_idx_q;
					end
					if (sample_idx_q != LAST_IDX) begin
						sample_idx_q <= sample_idx_q + IW'(1);
					end
					state_q <= last_q ? S_EMIT : S_IDLE;
				end
				S_EMIT: begin
					if (!out_valid_q || results.ready) begin
						out_valid_q  <= 1'b1;
						out_ratio_q  <= best_ratio_q;
						out_peak_q   <= best_peak_q;
						out_trough_q <= best_trough_q;
						if (sum_wide[SUM_W]) begin
							total_q   <= '1;
							out_sum_q <= '1;
						end else begin
							total_q   <= sum_wide[SUM_W-1:0];
							out_sum_q <= sum_wide[SUM_W-1:0];
						end
						peak_q        <= '0;
						peak_idx_q    <= '0;
						sample_idx_q  <= '0;
						best_ratio_q  <= '0;
						best_peak_q   <= '0;
						best_trough_q <= '0;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid     = out_valid_q;
	assign results.ratio_sum = out_sum_q;

	generate
		if (RB >= RATIO_W) begin : g_ratio_cut
			assign results.drawdown_ratio = out_ratio_q[RATIO_W-1:0];
		end else begin : g_ratio_ext
			assign results.drawdown_ratio = {{(RATIO_W - RB){1'b0}}, out_ratio_q};
		end
		if (IW >= POS_W) begin : g_pos_cut
			assign results.peak_position   = out_peak_q[POS_W-1:0];
			assign results.trough_position = out_trough_q[POS_W-1:0];
		end else begin : g_pos_ext
			assign results.peak_position   = {{(POS_W - IW){1'b0}}, out_peak_q};
			assign results.trough_position = {{(POS_W - IW){1'b0}}, out_trough_q};
		end
	endgenerate

endmodule

### test/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mdd_pkg::*;

	// The block is built with its default parameters, so the checker mirrors them.
	localparam int FRAC_BITS      = RATIO_FRACTION_BITS_DEF;
	localparam int LAST_INDEX     = MAX_SAMPLES_DEF - 1;
	localparam int DIVIDE_CYCLES  = FRAC_BITS + 5;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int RANDOM_SAMPLES = 1420;
	localparam int REPORT_LIMIT   = 40;

	localparam logic [FUND_W-1:0] TOP_VALUE   = '1;
	localparam logic [SUM_W-1:0]  SUM_CEILING = '1;

	// One finished series as the output channel reports it.
	typedef struct packed {
		logic [RATIO_W-1:0] ratio;
		logic [POS_W-1:0]   peak_pos;
		logic [POS_W-1:0]   trough_pos;
		logic [SUM_W-1:0]   sum;
	} drawdown_t;

	// Shapes of the random fund value series.
	typedef enum {
		VALUES_WIDE,
		VALUES_TINY,
		VALUES_WALK,
		VALUES_EXTREME
	} value_style_t;

	// Whether the result side holds back ready.
	typedef enum {
		STALL_OFF,
		STALL_ON
	} stall_mode_t;

	logic clk;
	logic arst_n;

	mdd_in_if  samples();
	mdd_out_if results();

	max_drawdown_tracker_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.samples(samples),
		.results(results)
	);

	// Drawdown state as the block should hold it after every accepted sample.
	logic [FUND_W-1:0]  run_peak;
	logic [POS_W-1:0]   run_peak_at;
	logic [POS_W-1:0]   sample_at;
	logic [RATIO_W-1:0] worst_drop;
	logic [POS_W-1:0]   worst_peak_at;
	logic [POS_W-1:0]   worst_trough_at;
	logic [SUM_W-1:0]   drop_total;

	// Results that accepted samples have promised, oldest first.
	drawdown_t expected_drawdowns[$];

	int samples_sent   = 0;
	int series_checked = 0;
	int mismatches     = 0;
	int stalled_cycles = 0;
	int burst_left     = 0;
	bit sender_gaps    = 1'b1;

	stall_mode_t stall_mode    = STALL_ON;
	logic [15:0] stall_pattern = '1;
	logic [3:0]  stall_phase   = '0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Drop ratio of one sample against the running peak. The value is
	// truncated toward zero; a zero sample below a live peak is exactly 1.0,
	// and a zero peak or a sample at or above the peak is no drop at all.
	function automatic logic [RATIO_W-1:0] drop_of(input logic [FUND_W-1:0] value,
			input logic [FUND_W-1:0] peak);
		logic [FUND_W+FRAC_BITS-1:0] scaled;
		if (peak == '0 || value >= peak)
			return '0;
		if (value == '0)
			return RATIO_W'(1) << FRAC_BITS;
		scaled = (FUND_W + FRAC_BITS)'(peak - value) << FRAC_BITS;
		return RATIO_W'(scaled / peak);
	endfunction

	// Advances the drawdown state by one sample. The peak moves only on a
	// strictly larger value and the worst drop only on a strictly larger
	// ratio, so the earliest of equal candidates keeps its position.
	function automatic void track_sample(input logic [FUND_W-1:0] value, input logic last);
		logic [RATIO_W-1:0] drop;
		logic [SUM_W:0]     sum;
		drawdown_t          finished;
		if (value > run_peak) begin
			run_peak = value;
			run_peak_at = sample_at;
		end
		drop = drop_of(value, run_peak);
		if (drop > worst_drop) begin
			worst_drop = drop;
			worst_peak_at = run_peak_at;
			worst_trough_at = sample_at;
		end
		// Samples past the index range all share the last index.
		if (sample_at != POS_W'(LAST_INDEX))
			sample_at = sample_at + POS_W'(1);
		if (!last)
			return;
		sum = {1'b0, drop_total} + (SUM_W + 1)'(worst_drop);
		drop_total = sum[SUM_W] ? SUM_CEILING : sum[SUM_W-1:0];
		finished.ratio = worst_drop;
		finished.peak_pos = worst_peak_at;
		finished.trough_pos = worst_trough_at;
		finished.sum = drop_total;
		expected_drawdowns.insert(expected_drawdowns.size(), finished);
		run_peak = '0;
		run_peak_at = '0;
		sample_at = '0;
		worst_drop = '0;
		worst_peak_at = '0;
		worst_trough_at = '0;
	endfunction

	// Next ready pattern for the result side. Patterns are 16 bits wide and
	// always hold at least one ready bit; all-ones gives stall-free stretches.
	function automatic logic [15:0] next_stall_pattern();
		if (stall_mode == STALL_OFF)
			return '1;
		case ($urandom_range(0, 3))
			0: return '1;
			1: return 16'h00FF;
			2: return 16'hAAAA;
			default: return 16'($urandom) | (16'h1 << $urandom_range(0, 15));
		endcase
	endfunction

	// A fund value of random magnitude: half of them full width so that every
	// bit is exercised, the rest shifted down to cover small values as well.
	function automatic logic [FUND_W-1:0] random_wide();
		logic [FUND_W-1:0] full;
		full = FUND_W'({$urandom, $urandom});
		if ($urandom_range(0, 1) == 0)
			return full;
		return full >> $urandom_range(1, FUND_W - 1);
	endfunction

	function automatic logic [FUND_W-1:0] next_value(input value_style_t style,
			input logic [FUND_W-1:0] prev);
		logic [FUND_W-1:0] step;
		case (style)
			VALUES_WIDE: return random_wide();
			// Small values make equal peaks, equal ratios and zeros common.
			VALUES_TINY: return FUND_W'($urandom_range(0, 15));
			VALUES_WALK: begin
				// A price-like walk: steps of up to a sixteenth of the last value.
				step = random_wide() % ({4'b0, prev[FUND_W-1:4]} + FUND_W'(1));
				if ($urandom_range(0, 1) == 0)
					return (prev > TOP_VALUE - step) ? TOP_VALUE : prev + step;
				return (step > prev) ? '0 : prev - step;
			end
			default: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return TOP_VALUE;
					2: return TOP_VALUE - FUND_W'(1);
					3: return prev;
					default: return random_wide();
				endcase
			end
		endcase
	endfunction

	// Sends one sample. The sender works in bursts; between bursts valid
	// drops for a random number of cycles unless gaps are switched off.
	// Valid stays high from one item to the next inside a burst.
	task automatic send_sample(input logic [FUND_W-1:0] value, input logic last);
		int gap;
		if (burst_left == 0) begin
			gap = sender_gaps ? $urandom_range(0, 8) : 0;
			if (gap > 0) begin
				samples.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		samples.valid <= 1'b1;
		samples.fund_value <= value;
		samples.series_end <= last;
		@(posedge clk);
		while (!samples.ready)
			@(posedge clk);
		track_sample(value, last);
		burst_left--;
		samples_sent++;
	endtask

	// Lowers valid and holds the sender until every promised result is in.
	task automatic wait_for_results();
		samples.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (expected_drawdowns.size() != 0)
			@(posedge clk);
	endtask

	task automatic check_field(input string field, input logic [SUM_W-1:0] want,
			input logic [SUM_W-1:0] got);
		if (want !== got) begin
			if (mismatches < REPORT_LIMIT)
				$error("%s mismatch: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endtask

	// Short hand-picked series: lone samples, zero peaks, full drops, the
	// widest values, tied peaks, tied ratios, rising series and a truncated
	// drop that rounds down to nothing.
	task automatic test_directed_cases();
		sender_gaps = 1'b1;
		stall_mode = STALL_ON;
		send_sample('0, 1'b1);
		send_sample(TOP_VALUE, 1'b1);
		send_sample('0, 1'b0);
		send_sample('0, 1'b0);
		send_sample(FUND_W'(5), 1'b1);
		send_sample(FUND_W'(1000), 1'b0);
		send_sample('0, 1'b1);
		send_sample(TOP_VALUE, 1'b0);
		send_sample(FUND_W'(1), 1'b1);
		send_sample(TOP_VALUE, 1'b0);
		send_sample(TOP_VALUE - FUND_W'(1), 1'b1);
		// The second 100 must not move the peak position.
		send_sample(FUND_W'(100), 1'b0);
		send_sample(FUND_W'(100), 1'b0);
		send_sample(FUND_W'(50), 1'b1);
		// The later half drop must not replace the earlier one.
		send_sample(FUND_W'(100), 1'b0);
		send_sample(FUND_W'(50), 1'b0);
		send_sample(FUND_W'(200), 1'b0);
		send_sample(FUND_W'(100), 1'b1);
		send_sample(FUND_W'(10), 1'b0);
		send_sample(FUND_W'(20), 1'b0);
		send_sample(FUND_W'(30), 1'b1);
		send_sample(FUND_W'(3), 1'b0);
		send_sample(FUND_W'(2), 1'b0);
		send_sample(TOP_VALUE, 1'b0);
		send_sample(TOP_VALUE >> 1, 1'b1);
		wait_for_results();
	endtask

	// Random series, mostly short with an occasional long one. Each series
	// picks its own value shape and its own idling on both sides. Halfway
	// through, the sender waits until all results are back.
	task automatic test_random_series();
		int           first_sample;
		int           length;
		bit           paused;
		value_style_t style;
		logic [FUND_W-1:0] value;
		first_sample = samples_sent;
		paused = 1'b0;
		while (samples_sent - first_sample < RANDOM_SAMPLES) begin
			length = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 300)
				: $urandom_range(1, 24);
			style = value_style_t'($urandom_range(0, 3));
			sender_gaps = ($urandom_range(0, 3) != 0);
			stall_mode = ($urandom_range(0, 3) != 0) ? STALL_ON : STALL_OFF;
			value = random_wide() | FUND_W'(1);
			for (int i = 0; i < length; i++) begin
				value = next_value(style, value);
				send_sample(value, i == length - 1);
			end
			if (!paused && samples_sent - first_sample >= RANDOM_SAMPLES / 2) begin
				wait_for_results();
				paused = 1'b1;
			end
		end
		wait_for_results();
	endtask

	// The result side stalls on its own 16-bit pattern, renewed at every wrap.
	always @(posedge clk) begin
		results.ready <= stall_pattern[stall_phase];
		stall_phase <= stall_phase + 4'd1;
		if (stall_phase == 4'd15)
			stall_pattern <= next_stall_pattern();
	end

	// Every accepted result is matched against the oldest promised one.
	always @(posedge clk) begin
		drawdown_t want;
		if (arst_n && results.valid && results.ready) begin
			if (expected_drawdowns.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$error("result item arrived with no series finished");
				mismatches++;
			end else begin
				want = expected_drawdowns.pop_front();
				check_field("drawdown_ratio", SUM_W'(want.ratio), SUM_W'(results.drawdown_ratio));
				check_field("peak_position", SUM_W'(want.peak_pos), SUM_W'(results.peak_position));
				check_field("trough_position", SUM_W'(want.trough_pos),
					SUM_W'(results.trough_position));
				check_field("ratio_sum", want.sum, results.ratio_sum);
				series_checked++;
			end
		end
	end

	// Counts cycles in which neither channel moves an item.
	always @(posedge clk) begin
		if (!arst_n || (samples.valid && samples.ready) || (results.valid && results.ready))
			stalled_cycles <= 0;
		else
			stalled_cycles <= stalled_cycles + 1;
	end

	initial begin
		wait (stalled_cycles >= WATCHDOG_LIMIT);
		$display("Watchdog: no item moved for %0d cycles.", WATCHDOG_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		run_peak = '0;
		run_peak_at = '0;
		sample_at = '0;
		worst_drop = '0;
		worst_peak_at = '0;
		worst_trough_at = '0;
		drop_total = '0;
		samples.valid <= 1'b0;
		samples.fund_value <= '0;
		samples.series_end <= 1'b0;
		arst_n <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_random_series();

		// Let any stray result surface before the verdict.
		repeat (2 * DIVIDE_CYCLES + 10) @(posedge clk);
		if (expected_drawdowns.size() != 0) begin
			$error("%0d results never arrived", expected_drawdowns.size());
			mismatches++;
		end
		$display("Sent %0d samples and checked %0d finished series: hand-picked edge values",
			samples_sent, series_checked);
		$display("and random series of mixed shapes under sender gaps and result stalls.");
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
